FILE: hdl/lu_pkg.sv
// Shared types and constants for the ledger update write logger.
// No dependencies; used by every module in hdl/.
`default_nettype none
package lu_pkg;

    localparam int ACCOUNTS_DEF     = 65536;
    localparam int CHUNKS_DEF       = 8;
    localparam int LOG_CAPACITY_DEF = 1048576;
    localparam int MAX_FILL_DEF     = 64;

    localparam int IDX_W  = 24;   // widest account index (16M accounts)
    localparam int CNT_W  = 7;    // fill entry count, up to 64
    localparam int AMT_W  = 32;
    localparam int BAL_W  = 64;
    localparam int FIN_W  = 60;   // index fields of the input word
    localparam int QDEPTH = 2;

    localparam logic [3:0] FN_XFER = 4'd0;
    localparam logic [3:0] FN_FILL = 4'd1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_BAD_FILL  = 3'd2;
    localparam logic [2:0] ST_BAD_CODES = 3'd3;
    localparam logic [2:0] ST_NOTHING   = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    localparam logic [1:0] K_STATUS = 2'd0;
    localparam logic [1:0] K_XFER   = 2'd1;
    localparam logic [1:0] K_FILL   = 2'd2;
    localparam logic [1:0] K_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0]       status;
        logic             s_ok;
        logic             r_ok;
        logic [IDX_W-1:0] sidx;
        logic [IDX_W-1:0] ridx;
        logic [CNT_W-1:0] cnt;
        logic [AMT_W-1:0] amt;
    } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/ledger_update_write_logger.sv
// Top level of the ledger update write logger: front, queue, back.
// Depends on lu_pkg, lu_front, lu_queue, lu_back.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_ready | mode, sender/receiver function+index, amount
//  out     | out_valid/out_ready | has_record, chunk_index, log_op,
//          |                     | account_index, new_balance, status, last
//
// Every command is popped from the queue in the idle state; a status-only
// result is issued in the cycle of the pop. After it a transfer reads, then
// writes, the memory for each written side, and a fill writes one entry per
// cycle while the result register is free. After reset a clearing pass
// zeroes the balance memory, during which in_ready stays low.
// A two-entry command queue decouples input from the balance sequencer;
// the result register only stalls the back end while out_ready is low.
`default_nettype none
module ledger_update_write_logger #(
    parameter int ACCOUNTS     = lu_pkg::ACCOUNTS_DEF,
    parameter int CHUNKS       = lu_pkg::CHUNKS_DEF,
    parameter int LOG_CAPACITY = lu_pkg::LOG_CAPACITY_DEF,
    parameter int MAX_FILL     = lu_pkg::MAX_FILL_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     mode,
    input  wire logic [3:0]               sender_function,
    input  wire logic [lu_pkg::FIN_W-1:0] sender_index,
    input  wire logic [3:0]               receiver_function,
    input  wire logic [lu_pkg::FIN_W-1:0] receiver_index,
    input  wire logic [lu_pkg::AMT_W-1:0] amount,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          has_record,
    output logic [2:0]                    chunk_index,
    output logic                          log_op,
    output logic [15:0]                   account_index,
    output logic signed [lu_pkg::BAL_W-1:0] new_balance,
    output logic [2:0]                    status,
    output logic                          last
);

    lu_pkg::cmd_t push_cmd;
    lu_pkg::cmd_t head;
    logic         push, pop, q_empty, q_full, init_done;

    // classify each transaction as it is accepted
    lu_front #(
        .ACCOUNTS (ACCOUNTS),
        .MAX_FILL (MAX_FILL)
    ) u_front (
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .sender_function   (sender_function),
        .sender_index      (sender_index),
        .receiver_function (receiver_function),
        .receiver_index    (receiver_index),
        .amount            (amount),
        .init_done         (init_done),
        .q_full            (q_full),
        .q_push            (push),
        .q_cmd             (push_cmd)
    );

    lu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // balance memory, write counts and result register
    lu_back #(
        .ACCOUNTS     (ACCOUNTS),
        .CHUNKS       (CHUNKS),
        .LOG_CAPACITY (LOG_CAPACITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_empty       (q_empty),
        .q_pop         (pop),
        .init_done     (init_done),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .has_record    (has_record),
        .chunk_index   (chunk_index),
        .log_op        (log_op),
        .account_index (account_index),
        .new_balance   (new_balance),
        .status        (status),
        .last          (last)
    );

endmodule
`default_nettype wire

FILE: hdl/lu_front.sv
// Front end: accepts input transactions and classifies them into commands.
// Depends on lu_pkg.
`default_nettype none
module lu_front #(
    parameter int ACCOUNTS = lu_pkg::ACCOUNTS_DEF,
    parameter int MAX_FILL = lu_pkg::MAX_FILL_DEF
) (
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     mode,
    input  wire logic [3:0]               sender_function,
    input  wire logic [lu_pkg::FIN_W-1:0] sender_index,
    input  wire logic [3:0]               receiver_function,
    input  wire logic [lu_pkg::FIN_W-1:0] receiver_index,
    input  wire logic [lu_pkg::AMT_W-1:0] amount,
    input  wire logic                     init_done,
    input  wire logic                     q_full,
    output logic                          q_push,
    output lu_pkg::cmd_t                  q_cmd
);

    logic s_ok;
    logic r_ok;
    logic [63:0] fill_end;
    logic bad_fill;

    assign in_ready = init_done && !q_full;
    assign q_push   = in_valid && in_ready;

    assign s_ok     = {4'b0, sender_index} < 64'(ACCOUNTS);
    assign r_ok     = {4'b0, receiver_index} < 64'(ACCOUNTS);
    assign fill_end = {4'b0, sender_index} + {4'b0, receiver_index};
    assign bad_fill = !s_ok || ({4'b0, receiver_index} > 64'(MAX_FILL))
                      || (fill_end > 64'(ACCOUNTS));

    always_comb
    begin
        q_cmd.kind   = lu_pkg::K_STATUS;
        q_cmd.status = lu_pkg::ST_BAD_CODES;
        q_cmd.s_ok   = s_ok;
        q_cmd.r_ok   = r_ok;
        q_cmd.sidx   = sender_index[lu_pkg::IDX_W-1:0];
        q_cmd.ridx   = receiver_index[lu_pkg::IDX_W-1:0];
        q_cmd.cnt    = receiver_index[lu_pkg::CNT_W-1:0];
        q_cmd.amt    = amount;
        if (mode)
        begin
            q_cmd.kind   = lu_pkg::K_CLEAR;
            q_cmd.status = lu_pkg::ST_CLEARED;
        end
        else if (sender_function == lu_pkg::FN_XFER && receiver_function == lu_pkg::FN_XFER)
        begin
            if (s_ok || r_ok)
                q_cmd.kind = lu_pkg::K_XFER;
            else
                q_cmd.status = lu_pkg::ST_NOTHING;
        end
        else if (sender_function == lu_pkg::FN_FILL && receiver_function == lu_pkg::FN_FILL)
        begin
            if (bad_fill)
                q_cmd.status = lu_pkg::ST_BAD_FILL;
            else if (receiver_index == '0)
                q_cmd.status = lu_pkg::ST_NOTHING;
            else
                q_cmd.kind = lu_pkg::K_FILL;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/lu_queue.sv
// Short command queue between front and back end.
// Depends on lu_pkg.
`default_nettype none
module lu_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire lu_pkg::cmd_t push_cmd,
    input  wire logic         pop,
    output lu_pkg::cmd_t      head,
    output logic              empty,
    output logic              full
);

    localparam int PW = $clog2(lu_pkg::QDEPTH);

    lu_pkg::cmd_t   slot_reg [lu_pkg::QDEPTH];
    logic [PW-1:0]  wp_reg;
    logic [PW-1:0]  rp_reg;
    logic [PW:0]    fill_reg;
    logic [PW:0]    fill_next;

    assign empty = fill_reg == '0;
    assign full  = fill_reg == (PW+1)'(lu_pkg::QDEPTH);
    assign head  = slot_reg[rp_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

FILE: hdl/lu_back.sv
// Back end: balance memory, per-chunk write counts and result register.
// Depends on lu_pkg.
`default_nettype none
module lu_back #(
    parameter int ACCOUNTS     = lu_pkg::ACCOUNTS_DEF,
    parameter int CHUNKS       = lu_pkg::CHUNKS_DEF,
    parameter int LOG_CAPACITY = lu_pkg::LOG_CAPACITY_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire lu_pkg::cmd_t head,
    input  wire logic         q_empty,
    output logic              q_pop,
    output logic              init_done,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              has_record,
    output logic [2:0]        chunk_index,
    output logic              log_op,
    output logic [15:0]       account_index,
    output logic signed [lu_pkg::BAL_W-1:0] new_balance,
    output logic [2:0]        status,
    output logic              last
);

    localparam int AW   = $clog2(ACCOUNTS);
    localparam int CHW  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CTW  = $clog2(LOG_CAPACITY + 1);
    localparam int SPAN = (ACCOUNTS + CHUNKS - 1) / CHUNKS;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [AW-1:0]            clr_reg;
    lu_pkg::cmd_t             cmd_reg;
    logic                     side_reg, side_next;
    logic [lu_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [CTW-1:0]           counts_reg [CHUNKS];

    logic [lu_pkg::BAL_W-1:0] mem [ACCOUNTS];
    logic [lu_pkg::BAL_W-1:0] rd_q;
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [lu_pkg::BAL_W-1:0] mem_wdata;

    logic                     out_free;
    logic                     emit, emit_rec, emit_last, emit_op, clear_counts;
    logic [2:0]               emit_status;
    logic [AW-1:0]            rec_idx;
    logic [lu_pkg::BAL_W-1:0] rec_bal;
    logic [CHW-1:0]           rec_chunk;
    logic                     rec_full;
    logic [AW-1:0]            side_idx;
    logic [AW-1:0]            fill_idx;

    logic                     out_valid_reg;
    logic                     has_record_reg;
    logic [2:0]               chunk_index_reg;
    logic                     log_op_reg;
    logic [15:0]              account_index_reg;
    logic [lu_pkg::BAL_W-1:0] new_balance_reg;
    logic [2:0]               status_reg;
    logic                     last_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign init_done = state_reg != S_CLR;
    assign side_idx  = side_reg ? AW'(cmd_reg.ridx) : AW'(cmd_reg.sidx);
    assign fill_idx  = AW'(cmd_reg.sidx) + AW'(pos_reg);

    // chunk of the written account by threshold compares
    always_comb
    begin
        rec_chunk = '0;
        for (int k = 1; k < CHUNKS; k++)
        begin
            if (32'(rec_idx) >= 32'(k * SPAN))
                rec_chunk = CHW'(k);
        end
    end
    assign rec_full = counts_reg[rec_chunk] >= CTW'(LOG_CAPACITY);

    always_comb
    begin
        state_next   = state_reg;
        side_next    = side_reg;
        pos_next     = pos_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = side_idx;
        mem_raddr    = side_idx;
        mem_wdata    = '0;
        emit         = 1'b0;
        emit_rec     = 1'b0;
        emit_last    = 1'b1;
        emit_op      = 1'b0;
        emit_status  = head.status;
        clear_counts = 1'b0;
        rec_idx      = side_idx;
        rec_bal      = '0;
        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == AW'(ACCOUNTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head.kind == lu_pkg::K_XFER)
                    begin
                        q_pop      = 1'b1;
                        side_next  = !head.s_ok;
                        state_next = S_RD;
                    end
                    else if (head.kind == lu_pkg::K_FILL)
                    begin
                        q_pop      = 1'b1;
                        pos_next   = '0;
                        state_next = S_FILL;
                    end
                    else if (out_free)
                    begin
                        q_pop        = 1'b1;
                        emit         = 1'b1;
                        clear_counts = head.kind == lu_pkg::K_CLEAR;
                    end
                end
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                rec_bal = side_reg ? rd_q + 64'(cmd_reg.amt) : rd_q - 64'(cmd_reg.amt);
                if (out_free)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = rec_bal;
                    emit        = 1'b1;
                    emit_rec    = 1'b1;
                    emit_status = rec_full ? lu_pkg::ST_OVERFLOW : lu_pkg::ST_OK;
                    emit_last   = side_reg || !cmd_reg.r_ok;
                    if (emit_last)
                        state_next = S_IDLE;
                    else
                    begin
                        side_next  = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_FILL:
            begin
                rec_idx   = fill_idx;
                rec_bal   = 64'(cmd_reg.amt);
                mem_waddr = fill_idx;
                if (out_free)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = rec_bal;
                    emit        = 1'b1;
                    emit_rec    = 1'b1;
                    emit_op     = 1'b1;
                    emit_status = rec_full ? lu_pkg::ST_OVERFLOW : lu_pkg::ST_OK;
                    emit_last   = pos_reg == cmd_reg.cnt - 1'b1;
                    pos_next    = pos_reg + 1'b1;
                    if (emit_last)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            side_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHUNKS; c++)
                counts_reg[c] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            pos_reg   <= pos_next;
            if (state_reg == S_CLR)
                clr_reg <= clr_reg + 1'b1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (clear_counts)
            begin
                for (int c = 0; c < CHUNKS; c++)
                    counts_reg[c] <= '0;
            end
            else if (emit_rec && !rec_full)
                counts_reg[rec_chunk] <= counts_reg[rec_chunk] + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= head;
        if (emit)
        begin
            has_record_reg    <= emit_rec;
            chunk_index_reg   <= emit_rec ? 3'(rec_chunk) : 3'd0;
            log_op_reg        <= emit_op;
            account_index_reg <= emit_rec ? 16'(rec_idx) : 16'd0;
            new_balance_reg   <= rec_bal;
            status_reg        <= emit_status;
            last_reg          <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign has_record    = has_record_reg;
    assign chunk_index   = chunk_index_reg;
    assign log_op        = log_op_reg;
    assign account_index = account_index_reg;
    assign new_balance   = new_balance_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

FILE: tb/tb_ledger_update_write_logger.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ledger update write logger.
// Depends on lu_pkg and the ledger_update_write_logger RTL.

// Tracks balances and per-chunk write counts. Predicts the write and status
// records of each transaction and compares the records coming out of the block.
class ledger_scoreboard;
    localparam int ACCTS  = 65536;
    localparam int NCHUNK = 8;
    localparam int SPAN   = (ACCTS + NCHUNK - 1) / NCHUNK;
    localparam int CAP    = 1048576;
    localparam int FILLMX = 64;

    typedef struct packed {
        logic        has_record;
        logic [2:0]  chunk_index;
        logic        log_op;
        logic [15:0] account_index;
        logic [63:0] new_balance;
        logic [2:0]  status;
        logic        last;
    } record_t;

    logic [63:0] balance_tbl [ACCTS];
    int unsigned chunk_writes [NCHUNK];
    record_t     pending_records [$];
    int          errors;

    function new();
        foreach (balance_tbl[i]) balance_tbl[i] = '0;
        foreach (chunk_writes[i]) chunk_writes[i] = 0;
        errors = 0;
    endfunction

    function void push_status(logic [2:0] st);
        record_t r;
        r = '0;
        r.status = st;
        pending_records.push_back(r);
    endfunction

    function void log_write(int unsigned idx, logic op);
        record_t r;
        int unsigned c;
        c = idx / SPAN;
        if (c >= NCHUNK) c = NCHUNK - 1;
        r = '0;
        r.has_record = 1'b1;
        r.chunk_index = c[2:0];
        r.log_op = op;
        r.account_index = idx[15:0];
        r.new_balance = balance_tbl[idx];
        if (chunk_writes[c] >= CAP)
            r.status = lu_pkg::ST_OVERFLOW;
        else
        begin
            r.status = lu_pkg::ST_OK;
            chunk_writes[c]++;
        end
        pending_records.push_back(r);
    endfunction

    // Note one accepted input transaction and queue its expected records.
    function void note_input(logic mode, logic [3:0] sfn, logic [59:0] sidx,
                             logic [3:0] rfn, logic [59:0] ridx, logic [31:0] amt);
        int n0;
        n0 = pending_records.size();
        if (mode)
        begin
            foreach (chunk_writes[i]) chunk_writes[i] = 0;
            push_status(lu_pkg::ST_CLEARED);
        end
        else if (sfn == lu_pkg::FN_XFER && rfn == lu_pkg::FN_XFER)
        begin
            if (sidx < ACCTS)
            begin
                balance_tbl[sidx] = balance_tbl[sidx] - {32'd0, amt};
                log_write(32'(sidx), 1'b0);
            end
            if (ridx < ACCTS)
            begin
                balance_tbl[ridx] = balance_tbl[ridx] + {32'd0, amt};
                log_write(32'(ridx), 1'b0);
            end
            if (pending_records.size() == n0) push_status(lu_pkg::ST_NOTHING);
        end
        else if (sfn == lu_pkg::FN_FILL && rfn == lu_pkg::FN_FILL)
        begin
            if (sidx >= ACCTS || ridx > FILLMX || sidx + ridx > ACCTS)
                push_status(lu_pkg::ST_BAD_FILL);
            else if (ridx == 0)
                push_status(lu_pkg::ST_NOTHING);
            else
                for (int unsigned i = 0; i < ridx; i++)
                begin
                    balance_tbl[sidx + i] = {32'd0, amt};
                    log_write(32'(sidx + i), 1'b1);
                end
        end
        else
            push_status(lu_pkg::ST_BAD_CODES);
        pending_records[$].last = 1'b1;
    endfunction

    task report(string what);
        errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // Compare one output record with the oldest expected record.
    task check_record(record_t got);
        record_t exp_r;
        if (pending_records.size() == 0)
        begin
            report($sformatf("unexpected record %h", got));
            return;
        end
        exp_r = pending_records.pop_front();
        if (got.has_record !== exp_r.has_record)
            report($sformatf("has_record %b exp %b", got.has_record, exp_r.has_record));
        if (got.chunk_index !== exp_r.chunk_index)
            report($sformatf("chunk_index %0d exp %0d", got.chunk_index, exp_r.chunk_index));
        if (got.log_op !== exp_r.log_op)
            report($sformatf("log_op %b exp %b", got.log_op, exp_r.log_op));
        if (got.account_index !== exp_r.account_index)
            report($sformatf("account_index %0d exp %0d",
                             got.account_index, exp_r.account_index));
        if (got.new_balance !== exp_r.new_balance)
            report($sformatf("new_balance %h exp %h", got.new_balance, exp_r.new_balance));
        if (got.status !== exp_r.status)
            report($sformatf("status %0d exp %0d", got.status, exp_r.status));
        if (got.last !== exp_r.last)
            report($sformatf("last %b exp %b", got.last, exp_r.last));
    endtask
endclass

module tb_ledger_update_write_logger;
    // Run ceiling: clearing pass plus 268 transactions of up to 64
    // records each, every record possibly waiting behind long stalls.
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic [3:0]  sender_function = '0;
    logic [59:0] sender_index = '0;
    logic [3:0]  receiver_function = '0;
    logic [59:0] receiver_index = '0;
    logic [31:0] amount = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        has_record;
    logic [2:0]  chunk_index;
    logic        log_op;
    logic [15:0] account_index;
    logic signed [63:0] new_balance;
    logic [2:0]  status;
    logic        last;

    ledger_scoreboard ledger;
    longint cycle_count = 0;
    int     send_idle_pct = 0;     // chance, in percent, the sender idles
    int     recv_stall_pct = 0;    // chance the receiver holds off
    int     hold_cycles = 0;       // forced long receiver hold-off

    always #1 clk = ~clk;

    ledger_update_write_logger DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .sender_function(sender_function), .sender_index(sender_index),
        .receiver_function(receiver_function), .receiver_index(receiver_index),
        .amount(amount),
        .out_valid(out_valid), .out_ready(out_ready),
        .has_record(has_record), .chunk_index(chunk_index), .log_op(log_op),
        .account_index(account_index), .new_balance(new_balance),
        .status(status), .last(last)
    );

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** ledger_update_write_logger: FAILED **");
            $finish;
        end
    end

    // Receiver side: random stalls plus an occasional long hold-off,
    // counted down here in its own process.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each result transaction against the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            ledger.check_record({has_record, chunk_index, log_op, account_index,
                                 new_balance, status, last});
    end

    // Offer one input transaction and hold it until accepted. Random idle
    // cycles go in front of it; valid stays up across back-to-back items.
    task send_txn(logic m, logic [3:0] sfn, logic [59:0] sidx,
                  logic [3:0] rfn, logic [59:0] ridx, logic [31:0] amt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        mode              <= m;
        sender_function   <= sfn;
        sender_index      <= sidx;
        receiver_function <= rfn;
        receiver_index    <= ridx;
        amount            <= amt;
        do @(posedge clk); while (!in_ready);
        ledger.note_input(m, sfn, sidx, rfn, ridx, amt);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (ledger.pending_records.size() != 0) @(posedge clk);
    endtask

    function logic [59:0] rand_idx60();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[59:0];
    endfunction

    // One random transaction, mostly well formed with random content.
    task random_txn();
        int pick;
        logic [59:0] s, r;
        logic [3:0] sf, rf;
        pick = $urandom_range(99);
        if (pick < 4)
            send_txn(1'b1, 4'($urandom()), rand_idx60(), 4'($urandom()),
                     rand_idx60(), $urandom());
        else if (pick < 55)
        begin
            // transfer; sides occasionally out of range
            s = ($urandom_range(9) == 0) ? rand_idx60() : 60'($urandom_range(65535));
            r = ($urandom_range(9) == 0) ? rand_idx60() : 60'($urandom_range(65535));
            if ($urandom_range(7) == 0) r = s;
            send_txn(1'b0, lu_pkg::FN_XFER, s, lu_pkg::FN_XFER, r, $urandom());
        end
        else if (pick < 88)
        begin
            // fill; mostly short, some at the limits or bad
            r = ($urandom_range(9) == 0) ? 60'($urandom_range(64)) : 60'($urandom_range(8));
            s = 60'($urandom_range(65536 - 64));
            if ($urandom_range(11) == 0) s = 60'(65536 - $urandom_range(8));
            if ($urandom_range(15) == 0) r = 60'($urandom_range(65, 200));
            if ($urandom_range(19) == 0) s = rand_idx60();
            send_txn(1'b0, lu_pkg::FN_FILL, s, lu_pkg::FN_FILL, r, $urandom());
        end
        else
        begin
            // noise codes
            sf = 4'($urandom());
            rf = ($urandom_range(1)) ? sf : 4'($urandom());
            send_txn(1'b0, sf, rand_idx60(), rf, rand_idx60(), $urandom());
        end
    endtask

    initial
    begin
        ledger = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of each field, every operation, each special case.
        send_txn(1'b0, lu_pkg::FN_XFER, 60'd0, lu_pkg::FN_XFER, 60'd65535, 32'hFFFF_FFFF);
        send_txn(1'b0, lu_pkg::FN_XFER, 60'd65535, lu_pkg::FN_XFER, 60'd0, 32'hFFFF_FFFF);
        send_txn(1'b0, lu_pkg::FN_XFER, 60'd7, lu_pkg::FN_XFER, 60'd7, 32'h1234_5678);
        send_txn(1'b0, lu_pkg::FN_XFER, 60'hFFF_FFFF_FFFF_FFFF, lu_pkg::FN_XFER,
                 60'd8191, 32'd5);
        send_txn(1'b0, lu_pkg::FN_XFER, 60'd8192, lu_pkg::FN_XFER,
                 60'hFFF_FFFF_FFFF_FFFF, 32'd1);
        send_txn(1'b0, lu_pkg::FN_XFER, 60'd65536, lu_pkg::FN_XFER, 60'd65536, 32'd9);
        send_txn(1'b0, lu_pkg::FN_XFER, 60'd100, lu_pkg::FN_XFER, 60'd101, 32'd0);
        send_txn(1'b0, lu_pkg::FN_FILL, 60'd0, lu_pkg::FN_FILL, 60'd64, 32'hFFFF_FFFF);
        send_txn(1'b0, lu_pkg::FN_FILL, 60'd65472, lu_pkg::FN_FILL, 60'd64, 32'h8000_0000);
        send_txn(1'b0, lu_pkg::FN_FILL, 60'd65535, lu_pkg::FN_FILL, 60'd1, 32'd3);
        send_txn(1'b0, lu_pkg::FN_FILL, 60'd65535, lu_pkg::FN_FILL, 60'd2, 32'd3);
        send_txn(1'b0, lu_pkg::FN_FILL, 60'd0, lu_pkg::FN_FILL, 60'd65, 32'd3);
        send_txn(1'b0, lu_pkg::FN_FILL, 60'd65536, lu_pkg::FN_FILL, 60'd0, 32'd3);
        send_txn(1'b0, lu_pkg::FN_FILL, 60'd50, lu_pkg::FN_FILL, 60'd0, 32'd3);
        send_txn(1'b0, lu_pkg::FN_FILL, 60'd10, lu_pkg::FN_FILL,
                 60'hFFF_FFFF_FFFF_FFFF, 32'd3);
        send_txn(1'b0, lu_pkg::FN_XFER, 60'd0, lu_pkg::FN_FILL, 60'd0, 32'd1);
        send_txn(1'b0, 4'hF, 60'd0, 4'hF, 60'd0, 32'd1);
        send_txn(1'b0, 4'h2, 60'd0, 4'h2, 60'd0, 32'd1);
        send_txn(1'b1, 4'hF, 60'hFFF_FFFF_FFFF_FFFF, 4'hA, 60'h555_5555_5555_5555,
                 32'hFFFF_FFFF);
        send_txn(1'b0, lu_pkg::FN_XFER, 60'h555_5555_5555_5555, lu_pkg::FN_XFER,
                 60'hAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);

        // Random traffic across idling phases.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            // long receiver hold-off while the sender keeps offering items
            if (ph == 0) hold_cycles = 400;
            for (int i = 0; i < 62; i++)
                random_txn();
            // sender pauses until every expected record has come back
            if (ph == 1) drain();
        end

        drain();
        repeat (200) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending_records.size() == 0)
            $display("** ledger_update_write_logger: PASSED **");
        else
            $display("** ledger_update_write_logger: FAILED **");
        $finish;
    end
endmodule
